>>> design/cdq_pkg.sv
// Shared types, widths and codes for the circular deque unit.
// No dependencies; used by cdq_cell and circular_deque_unit.
package cdq_pkg;

  localparam int unsigned CDQ_DEPTH = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic clear;
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_op_t;

endpackage

>>> design/cdq_cell.sv
// One entry of the deque cell row: a data word and its occupied bit.
// Depends on cdq_pkg (cdq_op_t, DATA_W).
module cdq_cell #(
  parameter int unsigned DataW = cdq_pkg::DATA_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cdq_pkg::cdq_op_t op_i,
  input  logic [DataW-1:0] push_data_i,
  input  logic [DataW-1:0] left_data_i,
  input  logic             left_valid_i,
  input  logic [DataW-1:0] right_data_i,
  input  logic             right_valid_i,
  output logic [DataW-1:0] data_o,
  output logic             valid_o
);

  logic [DataW-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (op_i.clear) begin
      valid_d = 1'b0;
    end else if (op_i.push_front) begin
      // whole row moves one cell toward the rear
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (op_i.push_rear) begin
      // first free cell takes the word
      if (!valid_q && left_valid_i) begin
        data_d  = push_data_i;
        valid_d = 1'b1;
      end
    end else if (op_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (op_i.pop_rear) begin
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

>>> design/circular_deque_unit.sv
// Top level of the circular deque unit: handshakes, capacity register, cell row.
// Depends on cdq_pkg and cdq_cell.
//
// Double-ended queue of signed 32-bit words. Each input word is a request
// (tuser: push front, push rear, pop front, pop rear; tdata: value to push)
// and yields exactly one result word. Entries sit in a row of DEPTH cells,
// the front always in cell 0 and the rest packed behind it; a push at the
// front or a pop from the front moves the whole row by one cell together,
// while rear operations touch only the cell at the boundary. Every
// result carries the popped value (zero for pushes and refused pops), the
// occupancy after the request and the words now at the front and the rear
// (zero when empty). A push beyond the configured capacity is dropped with
// status full; a pop from an empty deque returns status empty. Writing the
// capacity register (limited to 1..DEPTH, reset 16 or DEPTH if smaller)
// empties the deque; write it only while no result is outstanding. Once
// a request is accepted, its result shows in the output register on the
// next cycle, and the next request is taken once that result is taken;
// no new request is taken while a result waits. The front/rear fields
// are read from the cell row while the result waits, which holds the row still.
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::CDQ_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // [31:0] data_in
  input  logic [1:0]   s_axis_tuser,  // [1:0] req_type
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // [31:0] data_out, [36:32] occupancy,
                                      // [68:37] front_value, [100:69] rear_value
  output logic [1:0]   m_axis_tuser,  // [1:0] status
  // capacity register write
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i     // capacity_in_use
);

  localparam int unsigned DataW   = cdq_pkg::DATA_W;
  localparam int unsigned CapW    = cdq_pkg::CAP_W;
  localparam int unsigned CntFull = $clog2(DEPTH + 1);
  // count never exceeds the capacity, which fits the 5-bit register
  localparam int unsigned CntW    = (CntFull < CapW) ? CntFull : CapW;
  localparam int unsigned CapRst  = (cdq_pkg::CAP_RESET < DEPTH) ?
                                    cdq_pkg::CAP_RESET : DEPTH;

  // ---------------------------------------------------------------- control
  logic            in_accept, cfg_accept;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cap_q, cap_d;
  logic            full, empty;
  cdq_pkg::cdq_op_t op;

  assign s_axis_tready = !m_axis_tvalid;
  assign cfg_ready_o   = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_accept    = cfg_valid_i && cfg_ready_o;

  assign full  = (count_q >= cap_q);
  assign empty = (count_q == '0);

  always_comb begin
    op            = '0;
    op.clear      = cfg_accept;
    op.push_front = in_accept && (s_axis_tuser == cdq_pkg::REQ_PUSH_FRONT) && !full;
    op.push_rear  = in_accept && (s_axis_tuser == cdq_pkg::REQ_PUSH_REAR)  && !full;
    op.pop_front  = in_accept && (s_axis_tuser == cdq_pkg::REQ_POP_FRONT)  && !empty;
    op.pop_rear   = in_accept && (s_axis_tuser == cdq_pkg::REQ_POP_REAR)   && !empty;
  end

  // capacity limited to 1..DEPTH
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_d = CntW'(1);
    end else if (32'(cfg_data_i) > DEPTH) begin
      cap_d = CntW'(DEPTH);
    end else begin
      cap_d = CntW'(cfg_data_i);
    end
  end

  always_comb begin
    count_d = count_q;
    if (op.clear) begin
      count_d = '0;
    end else if (op.push_front || op.push_rear) begin
      count_d = count_q + CntW'(1);
    end else if (op.pop_front || op.pop_rear) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CntW'(CapRst);
    end else begin
      count_q <= count_d;
      if (cfg_accept) begin
        cap_q <= cap_d;
      end
    end
  end

  // --------------------------------------------------------------- cell row
  logic [DataW-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH-1:0] last_vec;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] left_data, right_data;
    logic             left_valid, right_valid;

    if (i == 0) begin : g_head
      // cell 0 sees the pushed word as its left neighbor
      assign left_data  = s_axis_tdata;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_data  = cell_data[i-1];
      assign left_valid = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_data  = cell_data[i+1];
      assign right_valid = valid_vec[i+1];
    end

    cdq_cell #(
      .DataW(DataW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .push_data_i  (s_axis_tdata),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .data_o       (cell_data[i]),
      .valid_o      (valid_vec[i])
    );
  end

  // rear is the one occupied cell whose right neighbor is free
  assign last_vec = valid_vec & ~(valid_vec >> 1);

  logic [DataW-1:0] front_cur, rear_cur;

  assign front_cur = valid_vec[0] ? cell_data[0] : '0;

  always_comb begin
    rear_cur = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_cur = rear_cur | (last_vec[i] ? cell_data[i] : '0);
    end
  end

  // ---------------------------------------------------------- result output
  logic                         out_valid_q;
  logic [DataW-1:0]             data_out_q;
  logic [cdq_pkg::STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept || (out_valid_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (!s_axis_tuser[1]) begin
        data_out_q <= '0;
        status_q   <= full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
      end else if (empty) begin
        data_out_q <= '0;
        status_q   <= cdq_pkg::ST_EMPTY;
      end else if (s_axis_tuser == cdq_pkg::REQ_POP_FRONT) begin
        data_out_q <= front_cur;
        status_q   <= cdq_pkg::ST_DONE;
      end else begin
        data_out_q <= rear_cur;
        status_q   <= cdq_pkg::ST_DONE;
      end
    end
  end

  // row is frozen while the result waits, so front/rear are live reads
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, rear_cur, front_cur,
                          cdq_pkg::OCC_W'(count_q), data_out_q};

  // ------------------------------------------------------------- assertions
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("occupancy above capacity");

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("occupied cells disagree with count");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("occupied cells not packed from the front");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid)
    else $error("accepted request gave no result");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == cdq_pkg::ST_FULL)) |-> (count_q == cap_q))
    else $error("push dropped while room was left");

endmodule

>>> tb/cdq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for circular_deque_unit: watches the request, result and capacity
// channels, keeps its own deque model and compares every result word field by field.
// Depends on cdq_pkg.
module cdq_checker
  import cdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic [DATA_W-1:0] req_data_i,
  input  logic [REQ_W-1:0]  req_kind_i,
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [103:0]      res_data_i,
  input  logic [STATUS_W-1:0] res_status_i,
  input  logic              cap_valid_i,
  input  logic              cap_ready_i,
  input  logic [CAP_W-1:0]  cap_data_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  localparam int unsigned IDX_W = $clog2(CDQ_DEPTH);

  typedef struct {
    logic [DATA_W-1:0]   popped;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
    logic [DATA_W-1:0]   front_word;
    logic [DATA_W-1:0]   rear_word;
  } deque_result_t;

  logic [DATA_W-1:0] ring_q [CDQ_DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic [OCC_W-1:0]  fill_cnt;
  logic [CAP_W-1:0]  cap_cur;

  deque_result_t awaited_q [$];
  deque_result_t due;
  int unsigned   error_cnt = 0;
  int unsigned   pending_cnt = 0;

  assign errors_o  = error_cnt;
  assign pending_o = pending_cnt;

  // out-of-range capacity folds into 1..DEPTH
  function automatic logic [CAP_W-1:0] cap_limit(logic [CAP_W-1:0] v);
    if (v == '0) return CAP_W'(1);
    if (int'(v) > int'(CDQ_DEPTH)) return CAP_W'(CDQ_DEPTH);
    return v;
  endfunction

  function automatic void empty_deque();
    head_idx = '0;
    tail_idx = IDX_W'(cap_cur - 1'b1);
    fill_cnt = '0;
  endfunction

  function automatic logic [IDX_W-1:0] slot_up(logic [IDX_W-1:0] i);
    return (int'(i) + 1 >= int'(cap_cur)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] slot_down(logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(cap_cur - 1'b1) : i - 1'b1;
  endfunction

  // apply one request to the model, return the result word it should produce
  function automatic deque_result_t deque_service(logic [REQ_W-1:0] kind,
                                                  logic [DATA_W-1:0] word);
    deque_result_t r;
    r.popped = '0;
    r.status = ST_DONE;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (fill_cnt >= cap_cur) begin
          r.status = ST_FULL;
        end else if (kind == REQ_PUSH_FRONT) begin
          head_idx = slot_down(head_idx);
          ring_q[head_idx] = word;
          fill_cnt = fill_cnt + 1'b1;
        end else begin
          tail_idx = slot_up(tail_idx);
          ring_q[tail_idx] = word;
          fill_cnt = fill_cnt + 1'b1;
        end
      end
      default: begin
        if (fill_cnt == '0) begin
          r.status = ST_EMPTY;
        end else if (kind == REQ_POP_FRONT) begin
          r.popped = ring_q[head_idx];
          head_idx = slot_up(head_idx);
          fill_cnt = fill_cnt - 1'b1;
        end else begin
          r.popped = ring_q[tail_idx];
          tail_idx = slot_down(tail_idx);
          fill_cnt = fill_cnt - 1'b1;
        end
      end
    endcase
    r.occ        = fill_cnt;
    r.front_word = (fill_cnt != '0) ? ring_q[head_idx] : '0;
    r.rear_word  = (fill_cnt != '0) ? ring_q[tail_idx] : '0;
    return r;
  endfunction

  function automatic void check_field(string what, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_q.delete();
      cap_cur = cap_limit(CAP_W'(CAP_RESET));
      empty_deque();
    end else begin
      // result first: it always belongs to an earlier request
      if (res_valid_i && res_ready_i) begin
        if (awaited_q.size() == 0) begin
          error_cnt++;
          $display("%0t: result word with none expected, actual %h / %h",
                   $time, res_data_i, res_status_i);
        end else begin
          due = awaited_q.pop_front();
          check_field("data_out", due.popped, res_data_i[31:0]);
          check_field("occupancy", DATA_W'(due.occ), DATA_W'(res_data_i[36:32]));
          check_field("front_value", due.front_word, res_data_i[68:37]);
          check_field("rear_value", due.rear_word, res_data_i[100:69]);
          check_field("tdata pad", '0, DATA_W'(res_data_i[103:101]));
          check_field("status", DATA_W'(due.status), DATA_W'(res_status_i));
        end
      end
      if (cap_valid_i && cap_ready_i) begin
        cap_cur = cap_limit(cap_data_i);
        empty_deque();
      end
      if (req_valid_i && req_ready_i)
        awaited_q.push_back(deque_service(req_kind_i, req_data_i));
    end
    pending_cnt = awaited_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the circular_deque_unit testbench: clock, reset, request and capacity
// stimulus, result back-pressure and the verdict. Depends on cdq_pkg and cdq_checker.
module tb_top;
  import cdq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata;   // [31:0] data_in
  logic [1:0]         s_axis_tuser;   // [1:0] req_type
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [103:0]       m_axis_tdata;   // [31:0] data_out, [36:32] occupancy,
                                      // [68:37] front_value, [100:69] rear_value
  logic [1:0]         m_axis_tuser;   // [1:0] status
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [4:0]         cfg_data_i;

  int unsigned error_cnt;
  int unsigned pending_cnt;
  bit          sender_steady;        // no gaps between request words

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  circular_deque_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  cdq_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_kind_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_status_i (m_axis_tuser),
    .cap_valid_i  (cfg_valid_i),
    .cap_ready_i  (cfg_ready_o),
    .cap_data_i   (cfg_data_i),
    .errors_o     (error_cnt),
    .pending_o    (pending_cnt)
  );

  // Drive one request word at a falling edge and hold it until taken.
  // Returns at the falling edge after the handshake.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Sender gap: mostly none, some short, a few long.
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!sender_steady) begin
      if (r >= 90)      n = $urandom_range(8, 30);
      else if (r >= 60) n = $urandom_range(1, 3);
    end
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Stop sending and wait until every result word has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Capacity writes only happen with the deque idle; each one empties it.
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side back-pressure: calm and choppy stretches picked at random.
  initial begin : rx_side
    int unsigned stall_left;
    int unsigned seg_left;
    bit          calm;
    stall_left = 0;
    seg_left   = 0;
    calm       = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (seg_left == 0) begin
        seg_left = $urandom_range(30, 300);
        calm     = ($urandom_range(0, 2) == 0);
      end
      seg_left--;
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                 : $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] corner_words [5];
    logic [CAP_W-1:0]  opening_caps [6];
    logic [CAP_W-1:0]  cap_val;
    logic [DATA_W-1:0] word;
    logic [REQ_W-1:0]  kind;
    int unsigned       random_cnt;
    int unsigned       phase_idx;
    int unsigned       phase_len;
    int unsigned       push_pct;
    int unsigned       run_left;
    int unsigned       r;
    bit                is_push;
    bit                at_rear;

    corner_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                     32'h0000_0001};
    // above DEPTH, two, just above DEPTH, DEPTH, one, three
    opening_caps = '{5'd31, 5'd2, 5'd17, 5'd16, 5'd1, 5'd3};

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PUSH_FRONT;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    sender_steady = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed, reset capacity: pops on empty, extreme words at both ends,
    // then drain from both ends down to empty and pop once more on empty.
    send_req(REQ_POP_FRONT, 32'hdead_beef);
    send_req(REQ_POP_REAR, 32'h1234_5678);
    send_req(REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_req(REQ_PUSH_REAR, 32'h8000_0000);
    send_req(REQ_PUSH_FRONT, 32'hffff_ffff);
    send_req(REQ_PUSH_REAR, 32'h0000_0000);
    send_req(REQ_POP_REAR, 32'hffff_ffff);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_REAR, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);

    // Capacity zero folds to one: full on both push kinds, empty on a rear pop.
    write_capacity(5'd0);
    send_req(REQ_PUSH_REAR, 32'h5555_5555);
    send_req(REQ_PUSH_FRONT, 32'haaaa_aaaa);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_REAR, 32'h0);
    send_req(REQ_PUSH_FRONT, 32'h0000_0001);
    send_req(REQ_PUSH_REAR, 32'h0000_0002);
    send_req(REQ_POP_REAR, 32'h0);

    // Random phases, each at its own capacity. Push bias switches between
    // filling, balanced and draining runs so both full and empty get hit.
    random_cnt = 0;
    phase_idx  = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      if (phase_idx < 6) begin
        cap_val = opening_caps[phase_idx];
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5)      cap_val = CAP_W'($urandom_range(1, 6));
        else if (r < 8) cap_val = CAP_W'($urandom_range(7, 16));
        else            cap_val = CAP_W'($urandom_range(0, 31));
      end
      phase_idx++;
      write_capacity(cap_val);
      sender_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 160);
      run_left  = 0;
      push_pct  = 50;
      for (int unsigned i = 0; i < phase_len; i++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(8, 30);
          r = $urandom_range(0, 2);
          push_pct = (r == 0) ? 85 : (r == 1) ? 50 : 15;
        end
        run_left--;
        is_push = ($urandom_range(0, 99) < push_pct);
        at_rear = $urandom_range(0, 1);
        if (is_push) kind = at_rear ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
        else         kind = at_rear ? REQ_POP_REAR : REQ_POP_FRONT;
        word = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 4)]
                                           : $urandom();
        send_req(kind, word);
        random_cnt++;
        idle_gap();
      end
    end

    drain();
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
